// File: hdl/cpot_pkg.sv
`default_nettype none
package cpot_pkg;
    localparam int MAX_VERTICES = 16;
    localparam int COORD_WIDTH = 16;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int VTX_W = 2 * COORD_WIDTH;
    localparam int DIF_W = COORD_WIDTH + 1;
    localparam int PRD_W = 2 * DIF_W;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIF_W-1:0] diff_t;
    typedef logic signed [PRD_W-1:0] prod_t;

    function automatic diff_t dsub(input coord_t a, input coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction
endpackage
`default_nettype wire

// File: hdl/cpot_ram.sv
`default_nettype none
module cpot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/convex_polygon_overlap_test_core.sv
// channel | ports                            | beat
// s_      | s_valid s_ready s_cmd s_coord_*  | one command: load a vertex or run
// m_      | m_valid m_ready m_hit ...        | one result per run command
// Loads are taken while idle. A run walks the two vertex memories through one
// read port each: first over every vertex of the larger polygon, closing vertex
// excluded, for the bounding boxes, then over the point tests both ways and the
// edge pairs, then raises the result; a box reject or a hit ends the walk early.
// Input is held off during a run and while a result waits. Reset is
// synchronous, active low, and clears counts, flags and the sequencer.
`default_nettype none
module convex_polygon_overlap_test_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_cmd,
    input  wire logic [cpot_pkg::COORD_WIDTH-1:0] s_coord_x,
    input  wire logic [cpot_pkg::COORD_WIDTH-1:0] s_coord_y,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_hit,
    output logic                                 m_overflowed,
    output logic                                 m_empty_polygon
);
    localparam int IW = cpot_pkg::IDX_W;
    localparam int CW = cpot_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BOX  = 3'd1;
    localparam logic [2:0] ST_PT   = 3'd2;
    localparam logic [2:0] ST_EDGE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic ovf_reg;
    logic m_valid_reg, hit_reg, ovr_reg, emp_reg;

    // sequencer: phase (0/1 read), counters i,j, pass (A in B / B in A)
    logic [2:0] ph_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic pass_reg;
    logic neg_any_reg, pos_any_reg;
    logic sp_reg;

    cpot_pkg::coord_t bxmin_a_reg, bxmax_a_reg, bymin_a_reg, bymax_a_reg;
    cpot_pkg::coord_t bxmin_b_reg, bxmax_b_reg, bymin_b_reg, bymax_b_reg;
    cpot_pkg::coord_t p0x_reg, p0y_reg, p1x_reg, p1y_reg, q0x_reg, q0y_reg;
    cpot_pkg::coord_t pxr_reg, pyr_reg;
    logic [1:0] n_sg_reg;

    logic we_a, we_b;
    logic [IW-1:0] ra_a, ra_b;
    logic [cpot_pkg::VTX_W-1:0] rd_a, rd_b;
    cpot_pkg::coord_t ax, ay, bx, by;

    assign ax = rd_a[cpot_pkg::VTX_W-1:cpot_pkg::COORD_WIDTH];
    assign ay = rd_a[cpot_pkg::COORD_WIDTH-1:0];
    assign bx = rd_b[cpot_pkg::VTX_W-1:cpot_pkg::COORD_WIDTH];
    assign by = rd_b[cpot_pkg::COORD_WIDTH-1:0];

    logic s_fire;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire = s_valid && s_ready;
    assign we_a = s_fire && s_cmd == cpot_pkg::CMD_LOAD_A &&
                  cnt_a_reg < CW'(cpot_pkg::MAX_VERTICES);
    assign we_b = s_fire && s_cmd == cpot_pkg::CMD_LOAD_B &&
                  cnt_b_reg < CW'(cpot_pkg::MAX_VERTICES);

    cpot_ram #(.WIDTH(cpot_pkg::VTX_W), .DEPTH(cpot_pkg::MAX_VERTICES)) u_ram_a (
        .aclk(aclk), .we(we_a), .waddr(cnt_a_reg[IW-1:0]),
        .wdata({s_coord_x, s_coord_y}), .raddr(ra_a), .rdata(rd_a));
    cpot_ram #(.WIDTH(cpot_pkg::VTX_W), .DEPTH(cpot_pkg::MAX_VERTICES)) u_ram_b (
        .aclk(aclk), .we(we_b), .waddr(cnt_b_reg[IW-1:0]),
        .wdata({s_coord_x, s_coord_y}), .raddr(ra_b), .rdata(rd_b));

    // sign of a*b - c*d, registered product stage
    cpot_pkg::diff_t ma, mb, mc, md;
    cpot_pkg::prod_t pab_reg, pcd_reg;
    logic [1:0] cmp;
    always_ff @(posedge aclk) begin
        pab_reg <= ma * mb;
        pcd_reg <= mc * md;
    end
    always_comb begin
        if (pab_reg > pcd_reg) begin
            cmp = 2'b01;
        end else if (pab_reg < pcd_reg) begin
            cmp = 2'b11;
        end else begin
            cmp = 2'b00;
        end
    end

    logic [CW-1:0] na_m1, nb_m1, last_a, last_b;
    assign na_m1 = cnt_a_reg - CW'(1);
    assign nb_m1 = cnt_b_reg - CW'(1);
    assign last_a = cnt_a_reg > CW'(2) ? cnt_a_reg - CW'(2) : '0;
    assign last_b = cnt_b_reg > CW'(2) ? cnt_b_reg - CW'(2) : '0;

    // polygon that holds points (outer loop) vs polygon tested (inner loop)
    logic [CW-1:0] n_in, n_out;
    assign n_out = pass_reg ? cnt_b_reg : cnt_a_reg;
    assign n_in  = pass_reg ? cnt_a_reg : cnt_b_reg;

    // edge-pair sign products, with their recorded cross signs
    logic [1:0] s_d1_reg, s_n1_reg;
    function automatic logic nonpos(input logic [1:0] u, input logic [1:0] v);
        return (u == 2'b00) || (v == 2'b00) || (u[1] != v[1]);
    endfunction

    always_comb begin
        ma = '0; mb = '0; mc = '0; md = '0;
        ra_a = '0; ra_b = '0;
        case (state_reg)
            ST_BOX: begin
                ra_a = i_reg[IW-1:0];
                ra_b = i_reg[IW-1:0];
            end
            ST_PT: begin
                // phase 0: read outer point i and inner vertex j; 1: j+1
                if (pass_reg) begin
                    ra_b = i_reg[IW-1:0];
                    ra_a = ph_reg == 3'd0 ? j_reg[IW-1:0] : IW'(j_reg + CW'(1));
                end else begin
                    ra_a = i_reg[IW-1:0];
                    ra_b = ph_reg == 3'd0 ? j_reg[IW-1:0] : IW'(j_reg + CW'(1));
                end
                // phase 2: vertex j in q0, j+1 on read data, point in pxr
                if (ph_reg == 3'd2) begin
                    ma = cpot_pkg::dsub(pyr_reg, pass_reg ? ay : by);
                    mb = cpot_pkg::dsub(pxr_reg, q0x_reg);
                    mc = cpot_pkg::dsub(pyr_reg, q0y_reg);
                    md = cpot_pkg::dsub(pxr_reg, pass_reg ? ax : bx);
                end
            end
            ST_EDGE: begin
                ra_a = ph_reg == 3'd0 ? i_reg[IW-1:0] : IW'(i_reg + CW'(1));
                ra_b = ph_reg == 3'd0 ? j_reg[IW-1:0] : IW'(j_reg + CW'(1));
                // p0=a[i], q0=b[j], p1=a[i+1], read data b=b[j+1]
                case (ph_reg)
                    3'd2: begin  // n1
                        ma = cpot_pkg::dsub(p0y_reg, by);
                        mb = cpot_pkg::dsub(p0x_reg, q0x_reg);
                        mc = cpot_pkg::dsub(p0x_reg, bx);
                        md = cpot_pkg::dsub(p0y_reg, q0y_reg);
                    end
                    3'd3: begin  // n2
                        ma = cpot_pkg::dsub(p1y_reg, pyr_reg);
                        mb = cpot_pkg::dsub(p1x_reg, q0x_reg);
                        mc = cpot_pkg::dsub(p1x_reg, pxr_reg);
                        md = cpot_pkg::dsub(p1y_reg, q0y_reg);
                    end
                    3'd4: begin  // d1
                        ma = cpot_pkg::dsub(pyr_reg, p1y_reg);
                        mb = cpot_pkg::dsub(pxr_reg, p0x_reg);
                        mc = cpot_pkg::dsub(pxr_reg, p1x_reg);
                        md = cpot_pkg::dsub(pyr_reg, p0y_reg);
                    end
                    3'd5: begin  // d2
                        ma = cpot_pkg::dsub(q0y_reg, p1y_reg);
                        mb = cpot_pkg::dsub(q0x_reg, p0x_reg);
                        mc = cpot_pkg::dsub(q0x_reg, p1x_reg);
                        md = cpot_pkg::dsub(q0y_reg, p0y_reg);
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        if (state_reg == ST_IDLE && s_fire && s_cmd == cpot_pkg::CMD_RUN) begin
            state_next = (cnt_a_reg == '0 || cnt_b_reg == '0) ? ST_DONE : ST_BOX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            ph_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            pass_reg <= 1'b0;
            hit_reg <= 1'b0;
            ovr_reg <= 1'b0;
            emp_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    state_reg <= state_next;
                    if (s_fire) begin
                        if (s_cmd == cpot_pkg::CMD_LOAD_A) begin
                            if (we_a) cnt_a_reg <= cnt_a_reg + CW'(1);
                            else ovf_reg <= 1'b1;
                        end else if (s_cmd == cpot_pkg::CMD_LOAD_B) begin
                            if (we_b) cnt_b_reg <= cnt_b_reg + CW'(1);
                            else ovf_reg <= 1'b1;
                        end else if (s_cmd == cpot_pkg::CMD_RUN) begin
                            hit_reg <= 1'b0;
                            ovr_reg <= ovf_reg;
                            emp_reg <= cnt_a_reg == '0 || cnt_b_reg == '0;
                            i_reg <= '0;
                            ph_reg <= '0;
                        end
                    end
                end
                ST_BOX: begin
                    if (ph_reg == '0) begin
                        ph_reg <= 3'd1;
                    end else begin
                        ph_reg <= '0;
                        if (i_reg == '0 || i_reg <= last_a) begin
                            if (i_reg == '0 || ax < bxmin_a_reg) bxmin_a_reg <= ax;
                            if (i_reg == '0 || ax > bxmax_a_reg) bxmax_a_reg <= ax;
                            if (i_reg == '0 || ay < bymin_a_reg) bymin_a_reg <= ay;
                            if (i_reg == '0 || ay > bymax_a_reg) bymax_a_reg <= ay;
                        end
                        if (i_reg == '0 || i_reg <= last_b) begin
                            if (i_reg == '0 || bx < bxmin_b_reg) bxmin_b_reg <= bx;
                            if (i_reg == '0 || bx > bxmax_b_reg) bxmax_b_reg <= bx;
                            if (i_reg == '0 || by < bymin_b_reg) bymin_b_reg <= by;
                            if (i_reg == '0 || by > bymax_b_reg) bymax_b_reg <= by;
                        end
                        if (i_reg >= last_a && i_reg >= last_b) begin
                            state_reg <= ST_PT;
                            sp_reg <= 1'b1;
                            i_reg <= '0;
                            j_reg <= '0;
                            pass_reg <= 1'b0;
                            neg_any_reg <= 1'b0;
                            pos_any_reg <= 1'b0;
                        end else begin
                            i_reg <= i_reg + CW'(1);
                        end
                    end
                end
                ST_PT: begin
                    if (sp_reg) begin
                        // bbox reject, skip empty passes, else hit if n_in <= 1
                        sp_reg <= 1'b0;
                        ph_reg <= '0;
                        if (bxmin_a_reg > bxmax_b_reg || bxmax_a_reg < bxmin_b_reg ||
                            bymin_a_reg > bymax_b_reg || bymax_a_reg < bymin_b_reg) begin
                            state_reg <= ST_DONE;
                        end else if (i_reg + CW'(1) >= n_out) begin
                            if (pass_reg) begin
                                state_reg <= ST_EDGE;
                                i_reg <= '0;
                                j_reg <= '0;
                            end else begin
                                pass_reg <= 1'b1;
                                sp_reg <= 1'b1;
                            end
                        end else if (n_in <= CW'(1)) begin
                            hit_reg <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        case (ph_reg)
                            3'd0: ph_reg <= 3'd1;
                            3'd1: begin
                                ph_reg <= 3'd2;
                                pxr_reg <= pass_reg ? bx : ax;
                                pyr_reg <= pass_reg ? by : ay;
                                q0x_reg <= pass_reg ? ax : bx;
                                q0y_reg <= pass_reg ? ay : by;
                            end
                            3'd2: ph_reg <= 3'd3;
                            default: begin
                                ph_reg <= '0;
                                if (j_reg + CW'(2) >= n_in) begin
                                    j_reg <= '0;
                                    neg_any_reg <= 1'b0;
                                    pos_any_reg <= 1'b0;
                                    if ((cmp == 2'b11 || !neg_any_reg) &&
                                        (cmp != 2'b11 || !pos_any_reg)) begin
                                        hit_reg <= 1'b1;
                                        state_reg <= ST_DONE;
                                    end else if (i_reg + CW'(2) >= n_out) begin
                                        i_reg <= '0;
                                        sp_reg <= 1'b1;
                                        if (pass_reg) begin
                                            state_reg <= ST_EDGE;
                                        end else begin
                                            pass_reg <= 1'b1;
                                        end
                                    end else begin
                                        i_reg <= i_reg + CW'(1);
                                    end
                                end else begin
                                    j_reg <= j_reg + CW'(1);
                                    if (cmp == 2'b11) neg_any_reg <= 1'b1;
                                    else pos_any_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_EDGE: begin
                    sp_reg <= 1'b0;
                    if (na_m1 == '0 || nb_m1 == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        case (ph_reg)
                            3'd0: ph_reg <= 3'd1;
                            3'd1: begin
                                ph_reg <= 3'd2;
                                p0x_reg <= ax; p0y_reg <= ay;
                                q0x_reg <= bx; q0y_reg <= by;
                            end
                            3'd2: begin
                                ph_reg <= 3'd3;
                                p1x_reg <= ax; p1y_reg <= ay;
                                pxr_reg <= bx; pyr_reg <= by;
                            end
                            3'd3: begin
                                ph_reg <= 3'd4;
                                n_sg_reg <= cmp;
                            end
                            3'd4: begin
                                ph_reg <= 3'd5;
                                s_n1_reg <= nonpos(n_sg_reg, cmp) ? 2'b00 : 2'b01;
                            end
                            3'd5: begin
                                ph_reg <= 3'd6;
                                s_d1_reg <= cmp;
                            end
                            default: begin
                                ph_reg <= '0;
                                if (s_n1_reg == 2'b00 && nonpos(s_d1_reg, cmp)) begin
                                    hit_reg <= 1'b1;
                                    state_reg <= ST_DONE;
                                end else if (j_reg + CW'(2) >= cnt_b_reg) begin
                                    j_reg <= '0;
                                    if (i_reg + CW'(2) >= cnt_a_reg) begin
                                        state_reg <= ST_DONE;
                                    end else begin
                                        i_reg <= i_reg + CW'(1);
                                    end
                                end else begin
                                    j_reg <= j_reg + CW'(1);
                                end
                            end
                        endcase
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        cnt_a_reg <= '0;
                        cnt_b_reg <= '0;
                        ovf_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit = hit_reg;
    assign m_overflowed = ovr_reg;
    assign m_empty_polygon = emp_reg;
endmodule
`default_nettype wire

// File: sim/convex_polygon_overlap_test_core_tb.sv
`default_nettype none
module convex_polygon_overlap_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] x;
        logic [15:0] y;
    } beat_t;

    typedef struct packed {
        logic hit;
        logic overflowed;
        logic empty_polygon;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [15:0] s_coord_x = '0;
    logic [15:0] s_coord_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit;
    logic        m_overflowed;
    logic        m_empty_polygon;

    convex_polygon_overlap_test_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_overflowed(m_overflowed), .m_empty_polygon(m_empty_polygon)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    beat_t    pending_beats[$];
    verdict_t expected_verdicts[$];
    longint   ax[cpot_pkg::MAX_VERTICES], ay[cpot_pkg::MAX_VERTICES];
    longint   bx[cpot_pkg::MAX_VERTICES], by[cpot_pkg::MAX_VERTICES];
    int       na = 0, nb = 0;
    bit       dropped = 1'b0;
    int       send_idle_pct = 0, recv_stall_pct = 0;
    int       hold_off_cycles = 0;
    bit       sender_paused = 1'b0;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    bit       stim_done = 1'b0;

    function automatic int cross_sign(longint a, longint b, longint c, longint d);
        longint p;
        p = a * b - c * d;
        if (p > 0) return 1;
        if (p < 0) return -1;
        return 0;
    endfunction

    function automatic bit covers_point(longint px, longint py, bit use_b);
        int n, neg;
        longint x0, y0, x1, y1;
        n = use_b ? nb : na;
        neg = 0;
        if (n <= 1) return 1'b1;
        for (int i = 0; i + 1 < n; i++) begin
            x0 = use_b ? bx[i] : ax[i];
            y0 = use_b ? by[i] : ay[i];
            x1 = use_b ? bx[i+1] : ax[i+1];
            y1 = use_b ? by[i+1] : ay[i+1];
            if (cross_sign(py - y1, px - x0, py - y0, px - x1) < 0) neg++;
        end
        return neg == 0 || neg == n - 1;
    endfunction

    function automatic bit polygons_touch();
        longint a_lo_x, a_hi_x, a_lo_y, a_hi_y, b_lo_x, b_hi_x, b_lo_y, b_hi_y;
        int n1, n2, d1, d2;
        a_lo_x = ax[0]; a_hi_x = ax[0]; a_lo_y = ay[0]; a_hi_y = ay[0];
        b_lo_x = bx[0]; b_hi_x = bx[0]; b_lo_y = by[0]; b_hi_y = by[0];
        for (int i = 1; i <= (na > 2 ? na - 2 : 0); i++) begin
            if (ax[i] < a_lo_x) a_lo_x = ax[i];
            if (ax[i] > a_hi_x) a_hi_x = ax[i];
            if (ay[i] < a_lo_y) a_lo_y = ay[i];
            if (ay[i] > a_hi_y) a_hi_y = ay[i];
        end
        for (int i = 1; i <= (nb > 2 ? nb - 2 : 0); i++) begin
            if (bx[i] < b_lo_x) b_lo_x = bx[i];
            if (bx[i] > b_hi_x) b_hi_x = bx[i];
            if (by[i] < b_lo_y) b_lo_y = by[i];
            if (by[i] > b_hi_y) b_hi_y = by[i];
        end
        if (a_lo_x > b_hi_x || a_hi_x < b_lo_x || a_lo_y > b_hi_y || a_hi_y < b_lo_y)
            return 1'b0;
        for (int i = 0; i + 1 < na; i++)
            if (covers_point(ax[i], ay[i], 1'b1)) return 1'b1;
        for (int i = 0; i + 1 < nb; i++)
            if (covers_point(bx[i], by[i], 1'b0)) return 1'b1;
        for (int i = 0; i + 1 < na; i++)
            for (int j = 0; j + 1 < nb; j++) begin
                n1 = cross_sign(ay[i] - by[j+1], ax[i] - bx[j], ax[i] - bx[j+1], ay[i] - by[j]);
                n2 = cross_sign(ay[i+1] - by[j+1], ax[i+1] - bx[j],
                                ax[i+1] - bx[j+1], ay[i+1] - by[j]);
                d1 = cross_sign(by[j+1] - ay[i+1], bx[j+1] - ax[i],
                                bx[j+1] - ax[i+1], by[j+1] - ay[i]);
                d2 = cross_sign(by[j] - ay[i+1], bx[j] - ax[i], bx[j] - ax[i+1], by[j] - ay[i]);
                if (d1 * d2 <= 0 && n1 * n2 <= 0) return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic void apply_beat(beat_t b);
        verdict_t v;
        case (b.cmd)
            cpot_pkg::CMD_LOAD_A: begin
                if (na < cpot_pkg::MAX_VERTICES) begin
                    ax[na] = longint'($signed(b.x)); ay[na] = longint'($signed(b.y)); na++;
                end else dropped = 1'b1;
            end
            cpot_pkg::CMD_LOAD_B: begin
                if (nb < cpot_pkg::MAX_VERTICES) begin
                    bx[nb] = longint'($signed(b.x)); by[nb] = longint'($signed(b.y)); nb++;
                end else dropped = 1'b1;
            end
            cpot_pkg::CMD_RUN: begin
                v.empty_polygon = (na == 0 || nb == 0);
                v.hit = v.empty_polygon ? 1'b0 : polygons_touch();
                v.overflowed = dropped;
                expected_verdicts.push_back(v);
                na = 0; nb = 0; dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                apply_beat('{cmd: s_cmd, x: s_coord_x, y: s_coord_y});
            end
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 && !sender_paused &&
                    $urandom_range(99) >= send_idle_pct) begin
                    {s_cmd, s_coord_x, s_coord_y} <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat");
                end else begin
                    verdict_t e;
                    e = expected_verdicts.pop_front();
                    if (e != {m_hit, m_overflowed, m_empty_polygon}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch hit/ovf/empty exp %b%b%b got %b%b%b",
                                     e.hit, e.overflowed, e.empty_polygon,
                                     m_hit, m_overflowed, m_empty_polygon);
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("convex_polygon_overlap_test_core_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [15:0] rand_coord(int spread);
        if ($urandom_range(15) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    function automatic void queue_beat(logic [1:0] c, logic [15:0] x, logic [15:0] y);
        pending_beats.push_back('{cmd: c, x: x, y: y});
    endfunction

    function automatic void queue_polygon(logic [1:0] c, int nv, int cx, int cy, int r);
        logic [15:0] fx, fy;
        int angle0;
        real t;
        angle0 = $urandom_range(359);
        for (int i = 0; i < nv; i++) begin
            t = (angle0 + i * 360.0 / nv) * 3.14159265 / 180.0;
            if (i == 0) begin
                fx = 16'(cx + int'(r * $cos(t)));
                fy = 16'(cy + int'(r * $sin(t)));
            end
            queue_beat(c, 16'(cx + int'(r * $cos(t))), 16'(cy + int'(r * $sin(t))));
        end
        queue_beat(c, fx, fy);
    endfunction

    task automatic drain();
        while (pending_beats.size() != 0 || s_valid || expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_block(int items);
        int sent, mode, k, span;
        sent = 0;
        while (sent < items) begin
            mode = $urandom_range(9);
            span = ($urandom_range(3) == 0) ? 32000 : 2000;
            if (mode < 7) begin
                k = $urandom_range(3, 7);
                queue_polygon(cpot_pkg::CMD_LOAD_A, k, int'($signed(rand_coord(span))) / 2,
                              int'($signed(rand_coord(span))) / 2, $urandom_range(1, span / 2));
                sent += k + 1;
                k = $urandom_range(3, 7);
                queue_polygon(cpot_pkg::CMD_LOAD_B, k, int'($signed(rand_coord(span))) / 2,
                              int'($signed(rand_coord(span))) / 2, $urandom_range(1, span / 2));
                sent += k + 1;
            end else begin
                k = $urandom_range(0, 6);
                for (int i = 0; i < k; i++)
                    queue_beat(2'($urandom_range(int'(CMD_UNUSED))), rand_coord(span),
                               rand_coord(span));
                sent += k;
            end
            queue_beat(cpot_pkg::CMD_RUN, 16'($urandom), 16'($urandom));
            sent++;
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        queue_beat(cpot_pkg::CMD_RUN, 16'h0000, 16'h0000);
        queue_beat(cpot_pkg::CMD_LOAD_A, 16'h7fff, 16'h8000);
        queue_beat(cpot_pkg::CMD_RUN, 16'hffff, 16'hffff);
        queue_beat(cpot_pkg::CMD_LOAD_A, 16'h0010, 16'h0010);
        queue_beat(cpot_pkg::CMD_LOAD_B, 16'h0010, 16'h0010);
        queue_beat(CMD_UNUSED, 16'h1234, 16'h5678);
        queue_beat(cpot_pkg::CMD_RUN, 16'h0000, 16'h0000);
        queue_beat(cpot_pkg::CMD_LOAD_A, 16'h8000, 16'h8000);
        queue_beat(cpot_pkg::CMD_LOAD_A, 16'h7fff, 16'h8000);
        queue_beat(cpot_pkg::CMD_LOAD_A, 16'h7fff, 16'h7fff);
        queue_beat(cpot_pkg::CMD_LOAD_A, 16'h8000, 16'h8000);
        queue_beat(cpot_pkg::CMD_LOAD_B, 16'h7fff, 16'h7fff);
        queue_beat(cpot_pkg::CMD_LOAD_B, 16'h8000, 16'h7fff);
        queue_beat(cpot_pkg::CMD_LOAD_B, 16'h8000, 16'h8000);
        queue_beat(cpot_pkg::CMD_LOAD_B, 16'h7fff, 16'h7fff);
        queue_beat(cpot_pkg::CMD_RUN, 16'h0000, 16'h0000);
        for (int i = 0; i < cpot_pkg::MAX_VERTICES + 2; i++)
            queue_beat(cpot_pkg::CMD_LOAD_A, 16'(i * 37), 16'(i * 91));
        queue_beat(cpot_pkg::CMD_LOAD_B, 16'h0005, 16'hfffb);
        queue_beat(cpot_pkg::CMD_RUN, 16'h0000, 16'h0000);
        drain();

        random_block(400);
        drain();
        send_idle_pct = 75;
        random_block(350);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 75;
        random_block(350);
        hold_off_cycles <= 3000;
        drain();
        sender_paused = 1'b1;
        random_block(100);
        repeat (50) @(posedge aclk);
        sender_paused = 1'b0;
        drain();
        send_idle_pct = 35;
        recv_stall_pct = 35;
        random_block(400);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_block(200);
        drain();

        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("convex_polygon_overlap_test_core_tb OK");
        end else begin
            $display("convex_polygon_overlap_test_core_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
